FILE: hw/rtl/polygon_scanline_span_fill_top_assert.svh
// Assertion macros used by the span fill top level.
`ifndef POLYGON_SCANLINE_SPAN_FILL_TOP_ASSERT_SVH
`define POLYGON_SCANLINE_SPAN_FILL_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define PSF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define PSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/psf_pkg.sv
`default_nettype none
package psf_pkg;

  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned MaxSpans       = 32;
  localparam int unsigned SpanW          = $clog2(MaxSpans);
  localparam int unsigned CrossW         = 40;

  typedef enum logic [1:0] {
    OP_NEW    = 2'd0,
    OP_APPEND = 2'd1,
    OP_ROW    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_SPAN  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DONE  = 2'd2,
    ST_FEW   = 2'd3
  } st_e;

  typedef enum logic [1:0] {
    BS_JM1 = 2'd0,
    BS_RP  = 2'd1,
    BS_RP1 = 2'd2
  } bsel_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_USE,
    S_SCAN_FIN,
    S_CHECK,
    S_PREV,
    S_EDGE_RD,
    S_EDGE_TEST,
    S_DIV,
    S_MUL,
    S_SUM,
    S_INS_RD,
    S_INS_CMP,
    S_EMIT_CHK,
    S_EMIT_RD0,
    S_EMIT_RD1,
    S_EMIT_OUT,
    S_OUT_EMPTY,
    S_OUT_FEW,
    S_OUT_DONE
  } state_e;

  typedef struct packed {
    logic  load;
    logic  row_start;
    logic  scan_upd;
    logic  scan_fin;
    logic  rd_last;
    logic  prev_latch;
    logic  edge_latch;
    logic  idx_inc;
    logic  div_step;
    logic  mul;
    logic  sum;
    bsel_e bsel;
    logic  bwr_key;
    logic  bwr_shift;
    logic  ins_done;
    logic  a_latch;
    logic  emit_adv;
    logic  out_load;
    st_e   out_kind;
    logic  row_inc;
  } psf_cmd_t;

  typedef struct packed {
    logic n_lt3;
    logic started;
    logic past_max;
    logic idx_last;
    logic crosses;
    logic div_last;
    logic j_zero;
    logic gt;
    logic pairs_ok;
    logic pair_last;
    logic out_free;
  } psf_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/psf_if.sv
`default_nettype none
interface psf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] vertex_x;
  logic [15:0] vertex_y;

  modport source (output valid, output op, output vertex_x, output vertex_y, input ready);
  modport sink   (input valid, input op, input vertex_x, input vertex_y, output ready);
endinterface

interface psf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] span_y;
  logic [15:0] span_x_start;
  logic [15:0] span_x_end;
  logic        last_of_row;

  modport source (output valid, output status, output span_y, output span_x_start,
                  output span_x_end, output last_of_row, input ready);
  modport sink   (input valid, input status, input span_y, input span_x_start,
                  input span_x_end, input last_of_row, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/psf_ctrl.sv
`default_nettype none
module psf_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [1:0]       in_op_i,
  output logic                  in_ready_o,
  input  wire psf_pkg::psf_sts_t sts_i,
  output psf_pkg::psf_cmd_t     cmd_o
);
  import psf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.bsel = BS_JM1;
    cmd_o.out_kind = ST_SPAN;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        // ready is high here, so valid alone marks an accepted request
        if (in_valid_i) begin
          unique case (in_op_i)
            OP_NEW, OP_APPEND: cmd_o.load = 1'b1;
            OP_ROW: begin
              cmd_o.row_start = 1'b1;
              if (sts_i.n_lt3)         state_d = S_OUT_FEW;
              else if (!sts_i.started) state_d = S_SCAN_RD;
              else                     state_d = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: state_d = S_SCAN_USE;
      S_SCAN_USE: begin
        cmd_o.scan_upd = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d = sts_i.idx_last ? S_SCAN_FIN : S_SCAN_RD;
      end
      S_SCAN_FIN: begin
        cmd_o.scan_fin = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.rd_last = 1'b1;
        state_d = sts_i.past_max ? S_OUT_DONE : S_PREV;
      end
      S_PREV: begin
        cmd_o.prev_latch = 1'b1;
        state_d = S_EDGE_RD;
      end
      S_EDGE_RD: state_d = S_EDGE_TEST;
      S_EDGE_TEST: begin
        cmd_o.edge_latch = 1'b1;
        if (sts_i.crosses) begin
          state_d = S_DIV;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = sts_i.idx_last ? S_EMIT_CHK : S_EDGE_RD;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d = S_INS_RD;
      end
      S_INS_RD: begin
        if (sts_i.j_zero) begin
          cmd_o.bwr_key  = 1'b1;
          cmd_o.ins_done = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          state_d = sts_i.idx_last ? S_EMIT_CHK : S_EDGE_RD;
        end else begin
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts_i.gt) begin
          // shift the larger crossing up one slot
          cmd_o.bwr_shift = 1'b1;
          state_d = S_INS_RD;
        end else begin
          cmd_o.bwr_key  = 1'b1;
          cmd_o.ins_done = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          state_d = sts_i.idx_last ? S_EMIT_CHK : S_EDGE_RD;
        end
      end
      S_EMIT_CHK: state_d = sts_i.pairs_ok ? S_EMIT_RD0 : S_OUT_EMPTY;
      S_EMIT_RD0: begin
        cmd_o.bsel = BS_RP;
        state_d = S_EMIT_RD1;
      end
      S_EMIT_RD1: begin
        cmd_o.bsel    = BS_RP1;
        cmd_o.a_latch = 1'b1;
        state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        cmd_o.bsel = BS_RP1;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.emit_adv = 1'b1;
          if (sts_i.pair_last) begin
            cmd_o.row_inc = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_EMIT_RD0;
          end
        end
      end
      S_OUT_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = ST_EMPTY;
          cmd_o.row_inc  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_OUT_FEW: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = ST_FEW;
          state_d = S_IDLE;
        end
      end
      S_OUT_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = ST_DONE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/psf_dp.sv
`default_nettype none
module psf_dp #(
  parameter int unsigned MaxVertices = psf_pkg::MaxVerticesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        in_op_i,
  input  wire logic [15:0]       in_vertex_x_i,
  input  wire logic [15:0]       in_vertex_y_i,
  input  wire psf_pkg::psf_cmd_t cmd_i,
  output psf_pkg::psf_sts_t      sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             out_status_o,
  output logic [15:0]            out_span_y_o,
  output logic [15:0]            out_span_x_start_o,
  output logic [15:0]            out_span_x_end_o,
  output logic                   out_last_of_row_o
);
  import psf_pkg::*;

  localparam int unsigned AW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned CW = $clog2(MaxVertices + 1);
  localparam int unsigned PW = CW + 1;

  // vertex store and crossing buffer
  logic signed [15:0]       vx_mem [MaxVertices];
  logic signed [15:0]       vy_mem [MaxVertices];
  logic signed [CrossW-1:0] cb_mem [MaxVertices];

  logic signed [15:0]       vx_rd_q, vy_rd_q;
  logic signed [CrossW-1:0] cb_rd_q;

  // control state
  logic [CW-1:0]     cnt_q;
  logic              started_q;
  logic signed [15:0] min_q, max_q;
  logic signed [16:0] cur_q;
  logic [AW-1:0]     idx_q;
  logic [CW-1:0]     ints_q;
  logic [CW-1:0]     j_q;
  logic [PW-1:0]     rp_q;
  logic [SpanW-1:0]  sc_q;
  logic [4:0]        dcnt_q;
  logic              out_valid_q;

  // payload registers
  logic signed [15:0]       px_q, py_q;
  logic [15:0]              d_q, dy_q;
  logic signed [16:0]       dx_q;
  logic signed [15:0]       x1_q;
  logic [16:0]              quo_q;
  logic [15:0]              rem_q;
  logic signed [34:0]       prod_q;
  logic signed [CrossW-1:0] key_q, a_q;
  logic [1:0]               st_q;
  logic [15:0]              oy_q, oxs_q, oxe_q;
  logic                     olast_q;

  // vertex write
  logic          vwr;
  logic [AW-1:0] vwa;
  always_comb begin
    vwr = 1'b0;
    vwa = cnt_q[AW-1:0];
    if (cmd_i.load) begin
      if (in_op_i == OP_NEW) begin
        vwr = 1'b1;
        vwa = '0;
      end else if (in_op_i == OP_APPEND && cnt_q < CW'(MaxVertices)) begin
        vwr = 1'b1;
      end
    end
  end

  logic [CW-1:0] n_m1;
  logic [AW-1:0] vra;
  assign n_m1 = cnt_q - CW'(1);
  assign vra  = cmd_i.rd_last ? n_m1[AW-1:0] : idx_q;

  always_ff @(posedge clk_i) begin
    if (vwr) begin
      vx_mem[vwa] <= in_vertex_x_i;
      vy_mem[vwa] <= in_vertex_y_i;
    end
    vx_rd_q <= vx_mem[vra];
    vy_rd_q <= vy_mem[vra];
  end

  // edge ordering and row test
  logic signed [15:0] ey1, ey2, ex1, ex2;
  logic signed [16:0] y1e, y2e, maxe;
  logic               crosses;
  always_comb begin
    if (py_q < vy_rd_q) begin
      ey1 = py_q;    ex1 = px_q;
      ey2 = vy_rd_q; ex2 = vx_rd_q;
    end else begin
      ey1 = vy_rd_q; ex1 = vx_rd_q;
      ey2 = py_q;    ex2 = px_q;
    end
    y1e  = 17'(ey1);
    y2e  = 17'(ey2);
    maxe = 17'(max_q);
    crosses = (cur_q >= y1e && cur_q < y2e) ||
              (cur_q == maxe && cur_q > y1e && cur_q <= y2e);
  end

  logic signed [16:0] dy_full, d_full, dx_full;
  assign dy_full = cur_q - y1e;
  assign d_full  = y2e - y1e;
  assign dx_full = 17'(ex2) - 17'(ex1);

  // restoring divider: the first step gives the top quotient bit, each later step one more bit
  logic        q_top;
  logic [16:0] rem2, rem2_sub;
  logic        rbit;
  assign q_top    = (dy_q >= d_q);
  assign rem2     = {rem_q, 1'b0};
  assign rem2_sub = rem2 - {1'b0, d_q};
  assign rbit     = (rem2 >= {1'b0, d_q});

  // crossing buffer access
  logic [CW-1:0] j_m1;
  logic [PW-1:0] rp_p1;
  logic [AW-1:0] cra;
  assign j_m1  = j_q - CW'(1);
  assign rp_p1 = rp_q + PW'(1);
  always_comb begin
    unique case (cmd_i.bsel)
      BS_RP:   cra = rp_q[AW-1:0];
      BS_RP1:  cra = rp_p1[AW-1:0];
      default: cra = j_m1[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bwr_key) begin
      cb_mem[j_q[AW-1:0]] <= key_q;
    end else if (cmd_i.bwr_shift) begin
      cb_mem[j_q[AW-1:0]] <= cb_rd_q;
    end
    cb_rd_q <= cb_mem[cra];
  end

  // rounding of the pulled-in pair ends
  logic signed [CrossW-1:0] va, vb;
  logic [15:0]              xs, xe;
  assign va = a_q + CrossW'(1);
  assign vb = cb_rd_q - CrossW'(1);
  assign xs = va[31:16] + {15'd0, va[15]};
  assign xe = vb[31:16] + {15'd0, vb[15]};

  logic [PW-1:0] rp_p4;
  assign rp_p4 = rp_q + PW'(4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      started_q   <= 1'b0;
      min_q       <= '0;
      max_q       <= '0;
      cur_q       <= '0;
      idx_q       <= '0;
      ints_q      <= '0;
      j_q         <= '0;
      rp_q        <= '0;
      sc_q        <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (in_op_i == OP_NEW) begin
          cnt_q     <= CW'(1);
          started_q <= 1'b0;
        end else if (in_op_i == OP_APPEND) begin
          if (cnt_q < CW'(MaxVertices)) cnt_q <= cnt_q + CW'(1);
          started_q <= 1'b0;
        end
      end
      if (cmd_i.row_start) idx_q <= '0;
      if (cmd_i.scan_upd) begin
        if (idx_q == '0) begin
          min_q <= vy_rd_q;
          max_q <= vy_rd_q;
        end else begin
          if (vy_rd_q < min_q) min_q <= vy_rd_q;
          if (vy_rd_q > max_q) max_q <= vy_rd_q;
        end
      end
      if (cmd_i.scan_fin) begin
        cur_q     <= 17'(min_q);
        started_q <= 1'b1;
      end
      if (cmd_i.prev_latch) begin
        idx_q  <= '0;
        ints_q <= '0;
        rp_q   <= '0;
        sc_q   <= '0;
      end
      if (cmd_i.idx_inc) idx_q <= idx_q + AW'(1);
      if (cmd_i.edge_latch) dcnt_q <= '0;
      if (cmd_i.div_step) dcnt_q <= dcnt_q + 5'd1;
      if (cmd_i.sum) j_q <= ints_q;
      if (cmd_i.bwr_shift) j_q <= j_m1;
      if (cmd_i.ins_done) ints_q <= ints_q + CW'(1);
      if (cmd_i.emit_adv) begin
        rp_q <= rp_q + PW'(2);
        sc_q <= sc_q + SpanW'(1);
      end
      if (cmd_i.row_inc) cur_q <= cur_q + 17'sd1;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prev_latch) begin
      px_q <= vx_rd_q;
      py_q <= vy_rd_q;
    end
    if (cmd_i.edge_latch) begin
      px_q <= vx_rd_q;
      py_q <= vy_rd_q;
      dy_q <= dy_full[15:0];
      d_q  <= d_full[15:0];
      dx_q <= dx_full;
      x1_q <= ex1;
    end
    if (cmd_i.div_step) begin
      if (dcnt_q == '0) begin
        quo_q <= {16'd0, q_top};
        rem_q <= q_top ? 16'd0 : dy_q;
      end else begin
        quo_q <= {quo_q[15:0], rbit};
        rem_q <= rbit ? rem2_sub[15:0] : rem2[15:0];
      end
    end
    if (cmd_i.mul) prod_q <= $signed({1'b0, quo_q}) * dx_q;
    if (cmd_i.sum) key_q <= CrossW'(prod_q) + {{(CrossW-32){x1_q[15]}}, x1_q, 16'd0};
    if (cmd_i.a_latch) a_q <= cb_rd_q;
    if (cmd_i.out_load) begin
      st_q <= cmd_i.out_kind;
      unique case (cmd_i.out_kind)
        ST_SPAN: begin
          oy_q    <= cur_q[15:0];
          oxs_q   <= xs;
          oxe_q   <= xe;
          olast_q <= sts_o.pair_last;
        end
        ST_EMPTY: begin
          oy_q    <= cur_q[15:0];
          oxs_q   <= '0;
          oxe_q   <= '0;
          olast_q <= 1'b1;
        end
        default: begin
          oy_q    <= '0;
          oxs_q   <= '0;
          oxe_q   <= '0;
          olast_q <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    sts_o.n_lt3     = (cnt_q < CW'(3));
    sts_o.started   = started_q;
    sts_o.past_max  = (cur_q > 17'(max_q));
    sts_o.idx_last  = ({1'b0, idx_q} == {1'b0, n_m1[AW-1:0]}) ;
    sts_o.crosses   = crosses;
    sts_o.div_last  = (dcnt_q == 5'd16);
    sts_o.j_zero    = (j_q == '0);
    sts_o.gt        = (cb_rd_q > key_q);
    sts_o.pairs_ok  = (ints_q >= CW'(2));
    sts_o.pair_last = (rp_p4 > {1'b0, ints_q}) || (sc_q == SpanW'(MaxSpans - 1));
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = st_q;
  assign out_span_y_o       = oy_q;
  assign out_span_x_start_o = oxs_q;
  assign out_span_x_end_o   = oxe_q;
  assign out_last_of_row_o  = olast_q;

endmodule
`default_nettype wire

FILE: hw/rtl/polygon_scanline_span_fill_top.sv
// Channel | Dir | Payload                                            | Transfer
// in_i    | in  | op, vertex_x, vertex_y                             | valid && ready
// out_o   | out | status, span_y, span_x_start, span_x_end, last_of_row | valid && ready
//
// A vertex load gives no result. A row request tests each edge of an n-vertex polygon
// (and on the first row also runs the min/max scan); each crossing then goes through
// the 17-step divider, multiply and insertion, with any insertion-sort shifts, and
// each span is read from the crossing buffer and sent.
// Both stores sit in single-read-port memories.
// rst_ni clears control state; a stall on out_o holds the controller until it frees.
`default_nettype none
module polygon_scanline_span_fill_top #(
  parameter int unsigned MaxVertices = psf_pkg::MaxVerticesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  psf_in_if.sink    in_i,
  psf_out_if.source out_o
);
  import psf_pkg::*;

`include "polygon_scanline_span_fill_top_assert.svh"

  psf_cmd_t cmd;
  psf_sts_t sts;
  logic     in_ready;
  logic     in_acc;

  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid && in_ready;

  psf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psf_dp #(
    .MaxVertices (MaxVertices)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_op_i            (in_i.op),
    .in_vertex_x_i      (in_i.vertex_x),
    .in_vertex_y_i      (in_i.vertex_y),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .out_status_o       (out_o.status),
    .out_span_y_o       (out_o.span_y),
    .out_span_x_start_o (out_o.span_x_start),
    .out_span_x_end_o   (out_o.span_x_end),
    .out_last_of_row_o  (out_o.last_of_row)
  );

  `PSF_ASSERT_IMP(a_load_free, cmd.out_load, sts.out_free)
  `PSF_ASSERT_NEXT(a_row_busy, in_acc && (in_i.op == OP_ROW), !in_i.ready)
  `PSF_ASSERT_NEXT(a_load_shown, cmd.out_load, out_o.valid)

endmodule
`default_nettype wire
